### design/hdf_pkg.sv
// ----------------------------------------------------------------------------
// hdf_pkg
// shared widths, constants and elaboration-time tables for the haversine block
// ----------------------------------------------------------------------------
package hdf_pkg;

  localparam int ANGLE_FRAC_BITS = 30;
  localparam int TRIG_ITERATIONS = 24;

  // signed datapath width for cordic x, y, z
  localparam int DW = ANGLE_FRAC_BITS + 4;
  // unsigned width of a value in [0, 1]
  localparam int UW = ANGLE_FRAC_BITS + 1;
  // square root residual width
  localparam int RW = 2 * ANGLE_FRAC_BITS + 3;

  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int RADIUS_W = 25;
  localparam int OUT_W    = 35;
  // signed width of a micro-degree difference
  localparam int MD_W     = 31;
  // unsigned width of a reduced micro-degree angle
  localparam int MDU_W    = 28;

  localparam logic signed [MD_W-1:0] TURN_MDEG     = 31'sd360000000;
  localparam logic signed [MD_W-1:0] TWO_TURN_MDEG = 31'sd720000000;
  localparam logic signed [MD_W-1:0] HALF_MDEG     = 31'sd180000000;
  localparam logic signed [MD_W-1:0] QUARTER_MDEG  = 31'sd90000000;

  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] GAIN_Q62 = 64'd2800459870029452953;
  localparam logic [63:0] KMD_Q62  = (PI_Q60 * 64'd4 + 64'd90000000) / 64'd180000000;
  localparam int KMD_W    = $clog2(KMD_Q62 + 64'd1);
  localparam int KMD_LO_W = KMD_W / 2;
  localparam int KMD_HI_W = KMD_W - KMD_LO_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(3956 * 5280);
  localparam logic [OUT_W-1:0]    OUT_MAX      = '1;

  // round a q62 constant to the angle format
  function automatic logic [63:0] q62_to_q(input logic [63:0] v);
    return (v + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS);
  endfunction

  // restoring division, constants only
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent of 2^-i: pi/4 for i = 0, else by its alternating series
  function automatic logic [63:0] atan_q(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int e;
    acc = '0;
    if (i == 0) begin
      return q62_to_q(PI_Q60);
    end
    for (int k = 0; k < 32; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        term = div_u64(64'd1 << e, 64'(2 * k + 1));
        if ((k & 1) != 0) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return q62_to_q(acc);
  endfunction

  localparam logic [63:0] GAIN_Q = q62_to_q(GAIN_Q62);

endpackage

### design/hdf_cordic_cell.sv
// ----------------------------------------------------------------------------
// hdf_cordic_cell
// one registered cordic micro-rotation, rotation or vectoring mode
// ----------------------------------------------------------------------------
module hdf_cordic_cell #(
  parameter int IDX = 0,
  parameter bit VEC = 1'b0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [hdf_pkg::DW-1:0]  x_i,
  input  logic signed [hdf_pkg::DW-1:0]  y_i,
  input  logic signed [hdf_pkg::DW-1:0]  z_i,
  output logic signed [hdf_pkg::DW-1:0]  x_o,
  output logic signed [hdf_pkg::DW-1:0]  y_o,
  output logic signed [hdf_pkg::DW-1:0]  z_o
);

  localparam logic signed [hdf_pkg::DW-1:0] ANG = hdf_pkg::DW'(hdf_pkg::atan_q(IDX));

  logic signed [hdf_pkg::DW-1:0] x_r, y_r, z_r;
  logic signed [hdf_pkg::DW-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [hdf_pkg::DW-1:0] dx, dy;
  logic                          cw;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    // clockwise step: vectoring drives y to zero, rotation drives z to zero
    cw = VEC ? (!y_i[hdf_pkg::DW-1] && (y_i != '0)) : z_i[hdf_pkg::DW-1];
    if (cw) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ANG;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

### design/hdf_sqrt_cell.sv
// ----------------------------------------------------------------------------
// hdf_sqrt_cell
// one registered bit of a restoring integer square root
// ----------------------------------------------------------------------------
module hdf_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [hdf_pkg::RW-1:0]  rem_i,
  input  logic [hdf_pkg::UW-1:0]  root_i,
  output logic [hdf_pkg::RW-1:0]  rem_o,
  output logic [hdf_pkg::UW-1:0]  root_o
);

  logic [hdf_pkg::RW-1:0] rem_r, rem_nxt, trial;
  logic [hdf_pkg::UW-1:0] root_r, root_nxt;

  always_comb begin
    // (root + 2^b)^2 - root^2
    trial = (hdf_pkg::RW'(root_i) << (BIT + 1)) + (hdf_pkg::RW'(1) << (2 * BIT));
    if (rem_i >= trial) begin
      rem_nxt  = rem_i - trial;
      root_nxt = root_i | (hdf_pkg::UW'(1) << BIT);
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

### design/haversine_distance_feet_top.sv
// ----------------------------------------------------------------------------
// haversine_distance_feet_top
// great-circle distance between two gps points, in 1/256 foot
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with four coordinates in signed
//   micro-degrees; a transaction is taken when in_valid is high and in_stall
//   is low. result channel: out_valid / out_stall with the distance.
//   cfg channel: cfg_valid / cfg_ready writes the sphere radius in feet;
//   cfg_ready is always high, write only while the pipe is empty
// throughput and pipeline
//   one transaction per cycle unless a stalled output freezes the pipe; the
//   pipe runs through the two rows of cordic cells and the row of square
//   root cells, each cell a register stage
// reset
//   rst_n low empties the pipe and loads the radius with 3956 miles in feet
// stall
//   the whole pipe freezes while a result is held on a stalled output;
//   in_stall then rises in the same cycle and bubbles keep their place
// ----------------------------------------------------------------------------
module haversine_distance_feet_top #(
  parameter int TRIG_ITERATIONS = hdf_pkg::TRIG_ITERATIONS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [hdf_pkg::LAT_W-1:0]      in_first_latitude,
  input  logic signed [hdf_pkg::LON_W-1:0]      in_first_longitude,
  input  logic signed [hdf_pkg::LAT_W-1:0]      in_second_latitude,
  input  logic signed [hdf_pkg::LON_W-1:0]      in_second_longitude,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [hdf_pkg::OUT_W-1:0]             out_distance_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hdf_pkg::RADIUS_W-1:0]          cfg_radius_feet
);

  localparam int F   = hdf_pkg::ANGLE_FRAC_BITS;
  localparam int DW  = hdf_pkg::DW;
  localparam int UW  = hdf_pkg::UW;
  localparam int RW  = hdf_pkg::RW;
  localparam int MDW = hdf_pkg::MD_W;
  localparam int MUW = hdf_pkg::MDU_W;
  localparam int LOW = MUW + hdf_pkg::KMD_LO_W;
  localparam int HIW = MUW + hdf_pkg::KMD_HI_W;
  localparam int PW  = MUW + hdf_pkg::KMD_W + 1;
  localparam int CW  = F + 3;
  localparam int DPW = CW + hdf_pkg::RADIUS_W + 1;
  localparam int LAT = 14 + 2 * TRIG_ITERATIONS + F + 1;

  localparam logic [UW-1:0] ONE_Q = UW'(1) << F;
  localparam logic [hdf_pkg::KMD_LO_W-1:0] KMD_LO =
    hdf_pkg::KMD_Q62[hdf_pkg::KMD_LO_W-1:0];
  localparam logic [hdf_pkg::KMD_HI_W-1:0] KMD_HI =
    hdf_pkg::KMD_Q62[hdf_pkg::KMD_W-1:hdf_pkg::KMD_LO_W];
  localparam logic signed [DW-1:0] GAIN = DW'(hdf_pkg::GAIN_Q);

  // pipe control: everything moves unless a result waits on a stalled output
  logic           adv;
  logic [LAT-1:0] vld_r, vld_nxt;
  logic [hdf_pkg::RADIUS_W-1:0] radius_r;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign vld_nxt   = {vld_r[LAT-2:0], in_valid};
  assign out_valid = vld_r[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= hdf_pkg::RADIUS_RESET;
    end else if (cfg_valid) begin
      radius_r <= cfg_radius_feet;
    end
  end

  // lanes: 0 latitude difference, 1 longitude difference,
  //        2 first latitude, 3 second latitude
  logic signed [MDW-1:0] s1_ang_r [4];
  logic signed [MDW-1:0] s2_ang_r [4];
  logic signed [MDW-1:0] s3_ang_r [4];
  logic [MUW-1:0]        s4_md_r  [4];
  logic [LOW-1:0]        s5_lo_r  [4];
  logic [HIW-1:0]        s5_hi_r  [4];
  logic signed [DW-1:0]  s6_th_r  [4];
  logic [1:0]            s4_neg_r, s5_neg_r, s6_neg_r;
  logic [1:0]            rot_neg_r [TRIG_ITERATIONS];

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ang_r[0] <= MDW'(in_second_latitude) - MDW'(in_first_latitude);
      s1_ang_r[1] <= MDW'(in_second_longitude) - MDW'(in_first_longitude);
      s1_ang_r[2] <= MDW'(in_first_latitude);
      s1_ang_r[3] <= MDW'(in_second_latitude);
    end
  end

  genvar l, j;
  generate
    for (l = 0; l < 4; l++) begin : g_front
      localparam int SH = 62 - F + ((l < 2) ? 1 : 0);
      logic [PW-1:0] sum;

      // stage 2: modulo a full turn into [0, 360e6)
      always_ff @(posedge clk) begin
        if (adv) begin
          if (s1_ang_r[l] < -hdf_pkg::TURN_MDEG) begin
            s2_ang_r[l] <= s1_ang_r[l] + hdf_pkg::TWO_TURN_MDEG;
          end else if (s1_ang_r[l] < 0) begin
            s2_ang_r[l] <= s1_ang_r[l] + hdf_pkg::TURN_MDEG;
          end else if (s1_ang_r[l] >= hdf_pkg::TURN_MDEG) begin
            s2_ang_r[l] <= s1_ang_r[l] - hdf_pkg::TURN_MDEG;
          end else begin
            s2_ang_r[l] <= s1_ang_r[l];
          end
        end
      end

      // stage 3: fold to [0, 180e6]
      always_ff @(posedge clk) begin
        if (adv) begin
          s3_ang_r[l] <= (s2_ang_r[l] > hdf_pkg::HALF_MDEG) ?
                         hdf_pkg::TURN_MDEG - s2_ang_r[l] : s2_ang_r[l];
        end
      end

      // stage 4: cosine lanes fold to [0, 90e6] and keep the sign
      if (l >= 2) begin : g_cos
        always_ff @(posedge clk) begin
          if (adv) begin
            if (s3_ang_r[l] > hdf_pkg::QUARTER_MDEG) begin
              s4_md_r[l]    <= MUW'(hdf_pkg::HALF_MDEG - s3_ang_r[l]);
              s4_neg_r[l-2] <= 1'b1;
            end else begin
              s4_md_r[l]    <= MUW'(s3_ang_r[l]);
              s4_neg_r[l-2] <= 1'b0;
            end
          end
        end
      end else begin : g_half
        always_ff @(posedge clk) begin
          if (adv) begin
            s4_md_r[l] <= MUW'(s3_ang_r[l]);
          end
        end
      end

      // stage 5: partial products of micro-degrees times pi/180e6
      always_ff @(posedge clk) begin
        if (adv) begin
          s5_lo_r[l] <= LOW'(s4_md_r[l]) * LOW'(KMD_LO);
          s5_hi_r[l] <= HIW'(s4_md_r[l]) * HIW'(KMD_HI);
        end
      end

      // stage 6: radians, rounded; the two difference lanes come out halved
      assign sum = (PW'(s5_hi_r[l]) << hdf_pkg::KMD_LO_W) + PW'(s5_lo_r[l]) +
                   (PW'(1) << (SH - 1));
      always_ff @(posedge clk) begin
        if (adv) begin
          s6_th_r[l] <= DW'(sum >> SH);
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_neg_r <= s4_neg_r;
      s6_neg_r <= s5_neg_r;
      rot_neg_r[0] <= s6_neg_r;
      for (int k = 1; k < TRIG_ITERATIONS; k++) begin
        rot_neg_r[k] <= rot_neg_r[k-1];
      end
    end
  end

  // rotation-mode cordic rows, one per lane
  logic signed [DW-1:0] rx [4][TRIG_ITERATIONS+1];
  logic signed [DW-1:0] ry [4][TRIG_ITERATIONS+1];
  logic signed [DW-1:0] rz [4][TRIG_ITERATIONS+1];

  generate
    for (l = 0; l < 4; l++) begin : g_rot
      assign rx[l][0] = GAIN;
      assign ry[l][0] = '0;
      assign rz[l][0] = s6_th_r[l];
      for (j = 0; j < TRIG_ITERATIONS; j++) begin : g_cell
        hdf_cordic_cell #(.IDX(j), .VEC(1'b0)) u_cell (
          .clk (clk),
          .en  (adv),
          .x_i (rx[l][j]),
          .y_i (ry[l][j]),
          .z_i (rz[l][j]),
          .x_o (rx[l][j+1]),
          .y_o (ry[l][j+1]),
          .z_o (rz[l][j+1])
        );
      end
    end
  endgenerate

  // clamp: sine for the half angles, cosine for the latitudes
  logic signed [DW-1:0] cl_raw [4];
  logic [UW-1:0]        cl_r [4];
  logic [1:0]           cl_neg_r;

  assign cl_raw[0] = ry[0][TRIG_ITERATIONS];
  assign cl_raw[1] = ry[1][TRIG_ITERATIONS];
  assign cl_raw[2] = rx[2][TRIG_ITERATIONS];
  assign cl_raw[3] = rx[3][TRIG_ITERATIONS];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        if (cl_raw[k][DW-1]) begin
          cl_r[k] <= '0;
        end else if (cl_raw[k] > DW'(ONE_Q)) begin
          cl_r[k] <= ONE_Q;
        end else begin
          cl_r[k] <= UW'(cl_raw[k]);
        end
      end
      cl_neg_r <= rot_neg_r[TRIG_ITERATIONS-1];
    end
  end

  // products, each rounded half up back to the unit format
  logic [2*UW-1:0] m_slat, m_slon, m_cc, m_term;
  logic [UW-1:0]   p1_slat_r, p1_slon_r, p1_cc_r, p2_slat_r, p2_term_r;
  logic            p1_neg_r, p2_neg_r;

  assign m_slat = (2*UW)'(cl_r[0]) * (2*UW)'(cl_r[0]) + ((2*UW)'(1) << (F - 1));
  assign m_slon = (2*UW)'(cl_r[1]) * (2*UW)'(cl_r[1]) + ((2*UW)'(1) << (F - 1));
  assign m_cc   = (2*UW)'(cl_r[2]) * (2*UW)'(cl_r[3]) + ((2*UW)'(1) << (F - 1));
  assign m_term = (2*UW)'(p1_cc_r) * (2*UW)'(p1_slon_r) + ((2*UW)'(1) << (F - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_slat_r <= m_slat[F+UW-1:F];
      p1_slon_r <= m_slon[F+UW-1:F];
      p1_cc_r   <= m_cc[F+UW-1:F];
      // a negative zero cosine does not flip the sign
      p1_neg_r  <= (cl_neg_r[0] && (cl_r[2] != '0)) ^ (cl_neg_r[1] && (cl_r[3] != '0));
      p2_slat_r <= p1_slat_r;
      p2_term_r <= m_term[F+UW-1:F];
      p2_neg_r  <= p1_neg_r;
    end
  end

  // a = sin^2(dlat/2) +- cos*cos*sin^2(dlon/2), clamped to [0, 1]
  logic signed [UW+1:0] a_sum;
  logic [UW-1:0]        a_r;
  logic [RW-1:0]        n_a_r, n_b_r;

  assign a_sum = p2_neg_r ? (UW+2)'(p2_slat_r) - (UW+2)'(p2_term_r)
                          : (UW+2)'(p2_slat_r) + (UW+2)'(p2_term_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (a_sum[UW+1]) begin
        a_r <= '0;
      end else if (a_sum > (UW+2)'(ONE_Q)) begin
        a_r <= ONE_Q;
      end else begin
        a_r <= UW'(a_sum);
      end
      // largest t with round(t*t / 2^F) <= v is isqrt(v*2^F + 2^(F-1) - 1)
      n_a_r <= (RW'(a_r) << F) + (RW'(1) << (F - 1)) - RW'(1);
      n_b_r <= (RW'(ONE_Q - a_r) << F) + (RW'(1) << (F - 1)) - RW'(1);
    end
  end

  // square root rows, one cell per result bit, msb first
  logic [RW-1:0] sq_rem  [2][F+2];
  logic [UW-1:0] sq_root [2][F+2];

  assign sq_rem[0][0]  = n_a_r;
  assign sq_rem[1][0]  = n_b_r;
  assign sq_root[0][0] = '0;
  assign sq_root[1][0] = '0;

  generate
    for (l = 0; l < 2; l++) begin : g_sqrt
      for (j = 0; j <= F; j++) begin : g_cell
        hdf_sqrt_cell #(.BIT(F - j)) u_cell (
          .clk    (clk),
          .en     (adv),
          .rem_i  (sq_rem[l][j]),
          .root_i (sq_root[l][j]),
          .rem_o  (sq_rem[l][j+1]),
          .root_o (sq_root[l][j+1])
        );
      end
    end
  endgenerate

  // vectoring row: half central angle = atan2(sqrt(a), sqrt(1-a))
  logic signed [DW-1:0] vx [TRIG_ITERATIONS+1];
  logic signed [DW-1:0] vy [TRIG_ITERATIONS+1];
  logic signed [DW-1:0] vz [TRIG_ITERATIONS+1];

  assign vx[0] = DW'(sq_root[1][F+1]);
  assign vy[0] = DW'(sq_root[0][F+1]);
  assign vz[0] = '0;

  generate
    for (j = 0; j < TRIG_ITERATIONS; j++) begin : g_vec
      hdf_cordic_cell #(.IDX(j), .VEC(1'b1)) u_cell (
        .clk (clk),
        .en  (adv),
        .x_i (vx[j]),
        .y_i (vy[j]),
        .z_i (vz[j]),
        .x_o (vx[j+1]),
        .y_o (vy[j+1]),
        .z_o (vz[j+1])
      );
    end
  endgenerate

  // central angle times radius, rounded to 1/256 foot, saturating
  logic signed [DW-1:0]  z_end;
  logic [CW-1:0]         c_r;
  logic [DPW-1:0]        d_prod_r, d_round;
  logic [hdf_pkg::OUT_W-1:0] out_r;

  assign z_end   = vz[TRIG_ITERATIONS];
  assign d_round = (d_prod_r + (DPW'(1) << (F - 9))) >> (F - 8);

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r      <= z_end[DW-1] ? '0 : {z_end[CW-2:0], 1'b0};
      d_prod_r <= DPW'(c_r) * DPW'(radius_r);
      if (d_round > DPW'(hdf_pkg::OUT_MAX)) begin
        out_r <= hdf_pkg::OUT_MAX;
      end else begin
        out_r <= hdf_pkg::OUT_W'(d_round);
      end
    end
  end

  assign out_distance_out = out_r;

endmodule
